@@ rtl/mmett_pkg.sv @@
// shared constants and codes for the multi-mode event timer table
`default_nettype none
package mmett_pkg;

  localparam int SLOTS       = 32;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int COUNT_LIMIT = 1024;
  localparam int CMD_W       = 3;
  localparam int MODE_W      = 3;
  localparam int TIME_W      = 32;
  localparam int COUNT_W     = 10;
  localparam int FSLOT_W     = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(COUNT_LIMIT - 1);

  // commands
  localparam logic [CMD_W-1:0] CMD_REGISTER = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WAKE     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SLEEP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CHMODE   = 3'd5;

  // run modes; erase pending is internal only
  localparam logic [MODE_W-1:0] MODE_LOOP       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COUNT      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_IVAL       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_IVAL_COUNT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WINDOW     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ERASE      = 3'd5;

  // result kinds
  localparam logic KIND_FIRE  = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

endpackage
`default_nettype wire

@@ rtl/mmett_if.sv @@
// command and result channel interfaces of the event timer table
`default_nettype none
interface mmett_in_if;
  logic                               valid;
  logic                               ready;
  logic [mmett_pkg::CMD_W-1:0]        cmd;
  logic [mmett_pkg::FSLOT_W-1:0]      slot;
  logic [mmett_pkg::MODE_W-1:0]       mode;
  logic [mmett_pkg::TIME_W-1:0]       interval;
  logic [mmett_pkg::COUNT_W-1:0]      run_count;
  logic [mmett_pkg::TIME_W-1:0]       time_now;

  modport source (output valid, cmd, slot, mode, interval, run_count, time_now,
                  input ready);
  modport sink   (input valid, cmd, slot, mode, interval, run_count, time_now,
                  output ready);
endinterface

interface mmett_out_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [mmett_pkg::FSLOT_W-1:0]      fired_slot;
  logic [mmett_pkg::COUNT_W-1:0]      remaining;
  logic                               removed;
  logic                               last;

  modport source (output valid, kind, fired_slot, remaining, removed, last,
                  input ready);
  modport sink   (input valid, kind, fired_slot, remaining, removed, last,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/multi_mode_event_timer_table.sv @@
// event timer table: slot store, command decode and sequential tick walker
//
// A table of 32 event slots driven by command beats on in_ch. Register,
// wake, sleep, erase and change-mode beats are accepted while idle and
// return nothing; the table is updated at the accepting edge and the next
// beat may follow in the next cycle.
// A tick beat starts a walk: one slot is examined per cycle, while the
// output register is free, in ascending order by a single shared
// subtract-and-compare unit (elapsed time against the stored interval).
// in_ch.ready is low while the walk runs and until the closing beat is
// loaded into the output register. Each slot that fires loads one beat
// into the out_ch output register; the closing beat (kind 1, last 1)
// follows the last slot.
// If the receiver stalls, the walk halts on the current slot until the
// output register is free.
// A command beat may be accepted while the closing beat still waits.
// Reset (rst_n low, synchronous) clears all slot valid bits, the output
// valid bit and the walker; slot contents are written before use.
`default_nettype none
module multi_mode_event_timer_table (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mmett_in_if.sink    in_ch,
  mmett_out_if.source out_ch
);

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_CLOSE} state_t;

  localparam logic [mmett_pkg::SLOT_W-1:0] LAST_IDX =
    mmett_pkg::SLOT_W'(mmett_pkg::SLOTS - 1);
  localparam logic [mmett_pkg::FSLOT_W:0] SLOT_LIM =
    (mmett_pkg::FSLOT_W+1)'(mmett_pkg::SLOTS);

  state_t                              state_r, state_nxt;
  logic [mmett_pkg::SLOT_W-1:0]        idx_r, idx_nxt;
  logic [mmett_pkg::TIME_W-1:0]        now_r, now_nxt;
  logic [mmett_pkg::SLOTS-1:0]         valid_r, valid_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic                                kind_r, kind_nxt;
  logic [mmett_pkg::FSLOT_W-1:0]       fired_slot_r, fired_slot_nxt;
  logic [mmett_pkg::COUNT_W-1:0]       remaining_r, remaining_nxt;
  logic                                removed_r, removed_nxt;
  logic                                last_r, last_nxt;

  // slot store, no reset
  logic [mmett_pkg::MODE_W-1:0]        mode_mem     [mmett_pkg::SLOTS];
  logic                                awake_mem    [mmett_pkg::SLOTS];
  logic                                active_mem   [mmett_pkg::SLOTS];
  logic [mmett_pkg::COUNT_W-1:0]       count_mem    [mmett_pkg::SLOTS];
  logic [mmett_pkg::TIME_W-1:0]        interval_mem [mmett_pkg::SLOTS];
  logic [mmett_pkg::TIME_W-1:0]        last_mem     [mmett_pkg::SLOTS];

  logic                                in_acc, out_free, step;
  logic [mmett_pkg::SLOT_W-1:0]        cmd_idx;
  logic                                slot_ok, mode_ok;
  logic [mmett_pkg::COUNT_W-1:0]       cnt_sat;

  logic [mmett_pkg::MODE_W-1:0]        w_mode;
  logic                                w_live;
  logic [mmett_pkg::COUNT_W-1:0]       w_cnt;
  logic [mmett_pkg::TIME_W-1:0]        w_pass;
  logic                                w_gt, w_nz;
  logic                                fired, gone, upd_last;
  logic [mmett_pkg::COUNT_W-1:0]       new_cnt;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign out_free          = !out_valid_r || out_ch.ready;
  assign step              = (state_r == ST_WALK) && out_free;

  assign cmd_idx  = in_ch.slot[mmett_pkg::SLOT_W-1:0];
  assign slot_ok  = {1'b0, in_ch.slot} < SLOT_LIM;
  assign mode_ok  = in_ch.mode <= mmett_pkg::MODE_WINDOW;
  assign cnt_sat  = (in_ch.run_count > mmett_pkg::COUNT_MAX) ? mmett_pkg::COUNT_MAX
                                                               : in_ch.run_count;

  // shared evaluation unit for the slot under the walker
  assign w_mode = mode_mem[idx_r];
  assign w_live = valid_r[idx_r] && awake_mem[idx_r] && active_mem[idx_r];
  assign w_cnt  = count_mem[idx_r];
  assign w_pass = now_r - last_mem[idx_r];
  assign w_gt   = w_pass > interval_mem[idx_r];
  assign w_nz   = w_cnt != '0;

  always_comb begin
    fired    = 1'b0;
    gone     = 1'b0;
    upd_last = 1'b0;
    new_cnt  = w_cnt;
    case (w_mode)
      mmett_pkg::MODE_LOOP: begin
        fired = 1'b1;
      end
      mmett_pkg::MODE_COUNT: begin
        fired   = w_nz;
        new_cnt = w_nz ? w_cnt - 1'b1 : w_cnt;
        gone    = !w_nz || (w_cnt == mmett_pkg::COUNT_W'(1));
      end
      mmett_pkg::MODE_IVAL: begin
        fired    = w_gt;
        upd_last = w_gt;
      end
      mmett_pkg::MODE_IVAL_COUNT: begin
        fired    = w_nz && w_gt;
        upd_last = w_nz && w_gt;
        new_cnt  = (w_nz && w_gt) ? w_cnt - 1'b1 : w_cnt;
        gone     = !w_nz || ((w_cnt == mmett_pkg::COUNT_W'(1)) && w_gt);
      end
      mmett_pkg::MODE_WINDOW: begin
        fired = 1'b1;
        gone  = !w_gt && (w_pass != interval_mem[idx_r]) ? 1'b0 : 1'b1;
      end
      mmett_pkg::MODE_ERASE: begin
        gone = 1'b1;
      end
      default: begin
        fired = 1'b0;
      end
    endcase
  end

  // sequencer, valid bits and output register
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    now_nxt        = now_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    kind_nxt       = kind_r;
    fired_slot_nxt = fired_slot_r;
    remaining_nxt  = remaining_r;
    removed_nxt    = removed_r;
    last_nxt       = last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.cmd == mmett_pkg::CMD_TICK) begin
            state_nxt = ST_WALK;
            idx_nxt   = '0;
            now_nxt   = in_ch.time_now;
          end else if (in_ch.cmd == mmett_pkg::CMD_REGISTER && slot_ok && mode_ok) begin
            valid_nxt[cmd_idx] = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (step) begin
          if (w_live) begin
            if (gone) valid_nxt[idx_r] = 1'b0;
            if (fired) begin
              out_valid_nxt  = 1'b1;
              kind_nxt       = mmett_pkg::KIND_FIRE;
              fired_slot_nxt = mmett_pkg::FSLOT_W'(idx_r);
              remaining_nxt  = new_cnt;
              removed_nxt    = gone;
              last_nxt       = 1'b0;
            end
          end
          if (idx_r == LAST_IDX) state_nxt = ST_CLOSE;
          else idx_nxt = idx_r + 1'b1;
        end
      end
      ST_CLOSE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          kind_nxt       = mmett_pkg::KIND_CLOSE;
          fired_slot_nxt = '0;
          remaining_nxt  = '0;
          removed_nxt    = 1'b0;
          last_nxt       = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    now_r        <= now_nxt;
    kind_r       <= kind_nxt;
    fired_slot_r <= fired_slot_nxt;
    remaining_r  <= remaining_nxt;
    removed_r    <= removed_nxt;
    last_r       <= last_nxt;
  end

  // slot store writes: commands at acceptance, walker updates per step
  always_ff @(posedge clk) begin
    if (in_acc && slot_ok) begin
      case (in_ch.cmd)
        mmett_pkg::CMD_REGISTER: begin
          if (mode_ok) begin
            awake_mem[cmd_idx]    <= 1'b1;
            active_mem[cmd_idx]   <= 1'b0;
            mode_mem[cmd_idx]     <= in_ch.mode;
            interval_mem[cmd_idx] <= in_ch.interval;
            count_mem[cmd_idx]    <= (in_ch.mode inside {mmett_pkg::MODE_COUNT,
                                       mmett_pkg::MODE_IVAL_COUNT}) ? cnt_sat : '0;
            last_mem[cmd_idx]     <= in_ch.time_now;
          end
        end
        mmett_pkg::CMD_WAKE: begin
          if (valid_r[cmd_idx]) begin
            awake_mem[cmd_idx]  <= 1'b1;
            active_mem[cmd_idx] <= 1'b1;
            if (mode_mem[cmd_idx] inside {mmett_pkg::MODE_IVAL,
                                          mmett_pkg::MODE_IVAL_COUNT})
              last_mem[cmd_idx] <= in_ch.time_now;
          end
        end
        mmett_pkg::CMD_SLEEP: begin
          if (valid_r[cmd_idx]) awake_mem[cmd_idx] <= 1'b0;
        end
        mmett_pkg::CMD_ERASE: begin
          if (valid_r[cmd_idx]) mode_mem[cmd_idx] <= mmett_pkg::MODE_ERASE;
        end
        mmett_pkg::CMD_CHMODE: begin
          if (valid_r[cmd_idx] && mode_ok) begin
            mode_mem[cmd_idx] <= in_ch.mode;
            if (in_ch.mode inside {mmett_pkg::MODE_COUNT, mmett_pkg::MODE_IVAL_COUNT})
              count_mem[cmd_idx] <= cnt_sat;
            if (!(in_ch.mode inside {mmett_pkg::MODE_LOOP, mmett_pkg::MODE_COUNT})) begin
              interval_mem[cmd_idx] <= in_ch.interval;
              last_mem[cmd_idx]     <= in_ch.time_now;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (step && w_live) begin
      count_mem[idx_r] <= new_cnt;
      if (upd_last) last_mem[idx_r] <= now_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.fired_slot = fired_slot_r;
  assign out_ch.remaining  = remaining_r;
  assign out_ch.removed    = removed_r;
  assign out_ch.last       = last_r;

endmodule
`default_nettype wire

@@ rtl/mmett_checker.sv @@
// port-level checks for the event timer table, bound to the top level
`default_nettype none
module mmett_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic [mmett_pkg::CMD_W-1:0]        in_cmd,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic                               out_kind,
  input wire logic [mmett_pkg::FSLOT_W-1:0]      out_fired_slot,
  input wire logic [mmett_pkg::COUNT_W-1:0]      out_remaining,
  input wire logic                               out_removed,
  input wire logic                               out_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_fired_slot) && $stable(out_remaining) && $stable(out_last))
    else $error("result beat changed while stalled");

  // a tick blocks further commands while the walk runs
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == mmett_pkg::CMD_TICK |=> !in_ready)
    else $error("ready high right after a tick");

  // closing beat carries nothing but the marker
  a_close_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == mmett_pkg::KIND_CLOSE |->
    out_last && out_fired_slot == '0 && out_remaining == '0 && !out_removed)
    else $error("malformed closing beat");

  a_fire_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == mmett_pkg::KIND_FIRE |-> !out_last)
    else $error("fire beat marked last");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind multi_mode_event_timer_table mmett_checker u_mmett_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_cmd         (in_ch.cmd),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.kind),
  .out_fired_slot (out_ch.fired_slot),
  .out_remaining  (out_ch.remaining),
  .out_removed    (out_ch.removed),
  .out_last       (out_ch.last)
);
`default_nettype wire
